@@ design/kal_pkg.sv @@
// Shared constants for the binary-lifting ancestor block.
// Holds field widths, function codes and register indexes.
// No dependencies.
`default_nettype none

package kal_pkg;

  localparam int NODE_W    = 10;  // node number width
  localparam int FUNC_W    = 2;   // function code width
  localparam int STEP_BITS = 11;  // width of the step count
  localparam int BIT_W     = 4;   // index into the step count
  localparam int PADDR_W   = 3;   // config byte address width
  localparam int PDATA_W   = 32;  // config data width

  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 10'd1023;

  // Function codes of an input beat
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // Register index, taken from paddr[PADDR_W-1]
  localparam logic CFG_NODE_COUNT = 1'b0;

endpackage

`default_nettype wire

@@ design/kal_req_if.sv @@
// Request channel: valid/ready handshake with one load, build or query beat.
// Depends on kal_pkg for field widths.
`default_nettype none

interface kal_req_if;

  logic                         valid;
  logic                         ready;
  logic [kal_pkg::FUNC_W-1:0]    func;
  logic [kal_pkg::NODE_W-1:0]    node;
  logic [kal_pkg::NODE_W-1:0]    parent_node;
  logic [kal_pkg::STEP_BITS-1:0] steps;

  modport source (output valid, func, node, parent_node, steps, input ready);
  modport sink   (input valid, func, node, parent_node, steps, output ready);

endinterface

`default_nettype wire

@@ design/kal_rsp_if.sv @@
// Response channel: valid/ready handshake with one result beat.
// Depends on kal_pkg for field widths.
`default_nettype none

interface kal_rsp_if;

  logic                      valid;
  logic                      ready;
  logic                      status;
  logic                      found;
  logic [kal_pkg::NODE_W-1:0] ancestor;

  modport source (output valid, status, found, ancestor, input ready);
  modport sink   (input valid, status, found, ancestor, output ready);

endinterface

`default_nettype wire

@@ design/kal_table.sv @@
// Ancestor table memory: one write (none during the sweep) and one registered read per cycle,
// plus a zeroing sweep after reset. Depends on kal_pkg for the entry width.
`default_nettype none

module kal_table #(
  parameter int LEVELS = 11,
  parameter int ROW_W  = 10,
  parameter int LVL_W  = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [LVL_W+ROW_W-1:0]      wr_addr_i,
  input  wire logic [kal_pkg::NODE_W-1:0]  wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [LVL_W+ROW_W-1:0]      rd_addr_i,
  output logic      [kal_pkg::NODE_W-1:0]  rd_data_o,
  output logic                             busy_o
);

  localparam int DEPTH  = LEVELS << ROW_W;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [kal_pkg::NODE_W-1:0] lift_mem [DEPTH];
  logic [kal_pkg::NODE_W-1:0] rd_data_q;
  logic [ADDR_W-1:0]          clr_addr_q;
  logic                       busy_q;

  // Sweep every entry to zero once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      busy_q     <= 1'b1;
    end else if (busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      lift_mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      lift_mem[ADDR_W'(wr_addr_i)] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= lift_mem[ADDR_W'(rd_addr_i)];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

`default_nettype wire

@@ design/kth_ancestor_binary_lifting.sv @@
// Binary-lifting k-th ancestor engine; needs kal_pkg, kal_req_if, kal_rsp_if, kal_table.
// One item at a time: each jump is a dependent read. Load and unused codes go via
//   S_DONE to the result register; a query loops S_QRY_SCAN (skipping zero step
//   bits) and S_QRY_WAIT per jump; a build per level: S_BLD_RD, then HOP/WR per node.
// Reset: the table sweeps all LEVELS*2^ceil(log2(rows)) entries (11264 by default) to zero;
//   no beat is accepted during the sweep, config writes still are.
`default_nettype none

module kth_ancestor_binary_lifting #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 11
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  kal_req_if.sink                            req_i,
  kal_rsp_if.source                          rsp_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kal_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [kal_pkg::PDATA_W-1:0]   pwdata,
  output logic      [kal_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  // Node numbers are NODE_W bits wide, so at most 2**NODE_W rows are reachable
  localparam int ROWS    = (MAX_NODES < (1 << kal_pkg::NODE_W)) ? MAX_NODES
                                                                : (1 << kal_pkg::NODE_W);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int TOP     = LEVELS - 1;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_MAX = ROWS - 1;
  localparam int NW      = kal_pkg::NODE_W;
  localparam int SB      = kal_pkg::STEP_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLD_RD,
    S_BLD_HOP,
    S_BLD_WR,
    S_QRY_SCAN,
    S_QRY_WAIT,
    S_DONE
  } state_e;

  // Stored ancestors outside the row range read as "no ancestor"
  function automatic logic [NW-1:0] clip(input logic [NW-1:0] v);
    clip = (int'(v) < ROWS) ? v : '0;
  endfunction

  state_e                     state_q;
  logic [NW-1:0]              node_count_q;
  logic [LVL_W-1:0]           lvl_q;
  logic [ROW_W-1:0]           j_q;
  logic                       hop_q;
  logic [NW-1:0]              cur_q;
  logic [SB-1:0]              hi_q;
  logic [SB-1:0]              low_q;
  logic [kal_pkg::BIT_W-1:0]  bit_q;
  logic                       res_status_q;
  logic                       res_found_q;
  logic [NW-1:0]              res_anc_q;
  logic                       out_valid_q;
  logic                       out_status_q;
  logic                       out_found_q;
  logic [NW-1:0]              out_anc_q;

  logic                       tbl_busy;
  logic                       wr_en;
  logic [LVL_W+ROW_W-1:0]     wr_addr;
  logic [NW-1:0]              wr_data;
  logic                       rd_en;
  logic [LVL_W+ROW_W-1:0]     rd_addr;
  logic [NW-1:0]              rd_data;

  logic [NW-1:0]              cnt;
  logic                       req_fire;
  logic                       load_ok;
  logic                       qry_ok;
  logic [SB-1:0]              steps_hi;
  logic [SB-1:0]              steps_lo;
  logic [LVL_W-1:0]           lvl_m1;
  logic [ROW_W-1:0]           j_nx;
  logic                       last_j;
  logic                       scan_end;
  logic                       scan_top;
  logic                       scan_bit;
  logic                       scan_jump;
  logic [LVL_W-1:0]           scan_lvl;
  logic                       cfg_wr;

  kal_table #(
    .LEVELS (LEVELS),
    .ROW_W  (ROW_W),
    .LVL_W  (LVL_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .busy_o    (tbl_busy)
  );

  // ---------------------------------------------------------------------------
  // Configuration port: one register, node_count; byte offset bits ignored
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
               && (paddr[kal_pkg::PADDR_W-1] == kal_pkg::CFG_NODE_COUNT);
  assign prdata = (paddr[kal_pkg::PADDR_W-1] == kal_pkg::CFG_NODE_COUNT)
                ? {{(kal_pkg::PDATA_W-NW){1'b0}}, node_count_q}
                : '0;

  // Effective count never exceeds the last reachable row
  assign cnt = (int'(node_count_q) > CNT_MAX) ? NW'(CNT_MAX) : node_count_q;

  assign req_i.ready = (state_q == S_IDLE) && !tbl_busy;
  assign req_fire    = req_i.valid && req_i.ready;
  assign load_ok     = (req_i.node != '0) && (req_i.node <= cnt) && (req_i.parent_node <= cnt);
  assign qry_ok      = (req_i.node != '0) && (req_i.node <= cnt);

  // Step bits at or above the top level all become top-level jumps, taken
  // first: their count is steps >> TOP. Lower bits each take one jump.
  assign steps_hi = req_i.steps >> TOP;
  always_comb begin
    for (int i = 0; i < SB; i++) begin
      steps_lo[i] = (i < TOP) ? req_i.steps[i] : 1'b0;
    end
  end

  // Build walk helpers
  assign lvl_m1 = lvl_q - 1'b1;
  assign j_nx   = j_q + 1'b1;
  assign last_j = (NW'(j_q) == cnt);

  // Query scan: top-level jumps first, then set low bits from high to low
  assign scan_end  = (cur_q == '0) || ((hi_q == '0) && (low_q == '0));
  assign scan_top  = (hi_q != '0);
  assign scan_bit  = low_q[bit_q];
  assign scan_jump = !scan_end && (scan_top || scan_bit);
  assign scan_lvl  = scan_top ? LVL_W'(TOP) : LVL_W'(bit_q);

  // ---------------------------------------------------------------------------
  // Table access per state
  // ---------------------------------------------------------------------------
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      S_IDLE: begin
        // Load writes level 0 in the accept cycle
        if (req_fire && (req_i.func == kal_pkg::FUNC_LOAD) && load_ok) begin
          wr_en   = 1'b1;
          wr_addr = {LVL_W'(0), ROW_W'(req_i.node)};
          wr_data = req_i.parent_node;
        end
      end
      S_BLD_RD: begin
        // First hop of a level: ancestor one level down
        rd_en   = 1'b1;
        rd_addr = {lvl_m1, j_q};
      end
      S_BLD_HOP: begin
        // Second hop: that ancestor's entry at the same level
        rd_en   = (clip(rd_data) != '0);
        rd_addr = {lvl_m1, ROW_W'(rd_data)};
      end
      S_BLD_WR: begin
        wr_en   = 1'b1;
        wr_addr = {lvl_q, j_q};
        wr_data = hop_q ? clip(rd_data) : '0;
        // Overlap the next node's first read; it hits the level below
        if (!last_j) begin
          rd_en   = 1'b1;
          rd_addr = {lvl_m1, j_nx};
        end
      end
      S_QRY_SCAN: begin
        rd_en   = scan_jump;
        rd_addr = {scan_lvl, ROW_W'(cur_q)};
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer, result holding and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= kal_pkg::NODE_COUNT_RST;
      lvl_q        <= '0;
      j_q          <= '0;
      hop_q        <= 1'b0;
      cur_q        <= '0;
      hi_q         <= '0;
      low_q        <= '0;
      bit_q        <= '0;
      res_status_q <= 1'b0;
      res_found_q  <= 1'b0;
      res_anc_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_found_q  <= 1'b0;
      out_anc_q    <= '0;
    end else begin
      if (cfg_wr) begin
        node_count_q <= pwdata[NW-1:0];
      end
      // Drop the output beat once taken; a finishing item refills it in S_DONE
      if (rsp_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            res_found_q <= 1'b0;
            res_anc_q   <= '0;
            case (req_i.func)
              kal_pkg::FUNC_LOAD: begin
                res_status_q <= !load_ok;
                state_q      <= S_DONE;
              end
              kal_pkg::FUNC_BUILD: begin
                res_status_q <= 1'b0;
                lvl_q        <= LVL_W'(1);
                j_q          <= ROW_W'(1);
                if ((TOP == 0) || (cnt == '0)) begin
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_BLD_RD;
                end
              end
              kal_pkg::FUNC_QUERY: begin
                res_status_q <= !qry_ok;
                cur_q        <= req_i.node;
                hi_q         <= steps_hi;
                low_q        <= steps_lo;
                bit_q        <= kal_pkg::BIT_W'(SB - 1);
                if (qry_ok) begin
                  state_q <= S_QRY_SCAN;
                end else begin
                  state_q <= S_DONE;
                end
              end
              default: begin
                res_status_q <= 1'b0;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_BLD_RD: begin
          state_q <= S_BLD_HOP;
        end
        S_BLD_HOP: begin
          hop_q   <= (clip(rd_data) != '0);
          state_q <= S_BLD_WR;
        end
        S_BLD_WR: begin
          if (last_j) begin
            if (lvl_q == LVL_W'(TOP)) begin
              state_q <= S_DONE;
            end else begin
              // Next level reads rows just written; restart without overlap
              lvl_q   <= lvl_q + 1'b1;
              j_q     <= ROW_W'(1);
              state_q <= S_BLD_RD;
            end
          end else begin
            j_q     <= j_nx;
            state_q <= S_BLD_HOP;
          end
        end
        S_QRY_SCAN: begin
          if (scan_end) begin
            res_found_q <= (cur_q != '0);
            res_anc_q   <= cur_q;
            state_q     <= S_DONE;
          end else if (scan_top) begin
            hi_q    <= hi_q - 1'b1;
            state_q <= S_QRY_WAIT;
          end else begin
            if (scan_bit) begin
              low_q[bit_q] <= 1'b0;
              state_q      <= S_QRY_WAIT;
            end
            if (bit_q != '0) begin
              bit_q <= bit_q - 1'b1;
            end
          end
        end
        S_QRY_WAIT: begin
          cur_q   <= clip(rd_data);
          state_q <= S_QRY_SCAN;
        end
        S_DONE: begin
          // Hold the result until the output register is free
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_found_q  <= res_found_q;
            out_anc_q    <= res_anc_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.found    = out_found_q;
  assign rsp_o.ancestor = out_anc_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != S_IDLE))
    else $error("accepted beat did not start work");

  a_found_matches_anc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.found == (rsp_o.ancestor != '0)))
    else $error("found flag disagrees with ancestor");

  a_bad_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status) |-> (!rsp_o.found && (rsp_o.ancestor == '0)))
    else $error("error result carries an ancestor");

  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_QRY_SCAN) || (state_q == S_QRY_WAIT)) |-> !wr_en)
    else $error("table written during a query");

  a_sweep_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_busy |-> !req_i.ready)
    else $error("beat accepted during table sweep");

endmodule

`default_nettype wire
